/* rtl/sltbc_pkg.sv */
// ----------------------------------------------------------------------------
// sltbc_pkg
// Shared widths and status types for the single-line table block cache.
// ----------------------------------------------------------------------------
package sltbc_pkg;

  // entry data width
  localparam int DATA_W = 32;
  // page field width at the ports
  localparam int PAGE_IN_W = 20;
  // block number width at the result ports
  localparam int OUT_BLK_W = 10;

  // status from the back part to the top level
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

/* rtl/sltbc_ram.sv */
// ----------------------------------------------------------------------------
// sltbc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sltbc_ram #(
  parameter int W = 32,
  parameter int D = 1024,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sltbc_fifo.sv */
// ----------------------------------------------------------------------------
// sltbc_fifo
// Two-entry queue between the front decode and the back copy engine.
// ----------------------------------------------------------------------------
module sltbc_fifo #(
  parameter int EW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [EW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic [EW-1:0] dout,
  output logic          empty
);

  logic [EW-1:0] slot_r [2];
  logic          wptr_r;
  logic          rptr_r;
  logic [1:0]    cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = slot_r[rptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr_r <= ~wptr_r;
      end
      if (pop && !empty) begin
        rptr_r <= ~rptr_r;
      end
      case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wptr_r] <= din;
    end
  end

endmodule

/* rtl/sltbc_front.sv */
// ----------------------------------------------------------------------------
// sltbc_front
// Accepts a request word and splits its page into block and offset with a
// reciprocal multiply and a remainder step, then queues the decoded word for
// the back part.
// ----------------------------------------------------------------------------
module sltbc_front #(
  parameter int PAGE_BITS    = 20,
  parameter int LINE_ENTRIES = 1024,
  localparam int LAW = $clog2(LINE_ENTRIES),
  localparam int NUM_BLK = ((1 << PAGE_BITS) + LINE_ENTRIES - 1) / LINE_ENTRIES,
  localparam int BW = (NUM_BLK > 1) ? $clog2(NUM_BLK) : 1,
  localparam int EW = 2 + BW + LAW + sltbc_pkg::DATA_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            take,
  input  logic                            opcode,
  input  logic                            table_sel,
  input  logic [sltbc_pkg::PAGE_IN_W-1:0] page,
  input  logic [sltbc_pkg::DATA_W-1:0]    value,
  output logic                            busy,
  output logic                            push,
  output logic [EW-1:0]                   entry,
  input  logic                            full
);

  // quotient by multiply: exact for every page below 2^PAGE_BITS
  localparam int     SH      = PAGE_BITS + LAW;
  localparam int     MW      = PAGE_BITS + 1;
  localparam int     PW      = PAGE_BITS + MW;
  localparam longint RECIP   = ((longint'(1) << SH) + longint'(LINE_ENTRIES) - 1) /
                               longint'(LINE_ENTRIES);
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_REM, F_PUSH} fstate_t;

  fstate_t                       state_r;
  logic                          op_r;
  logic                          t_r;
  logic [sltbc_pkg::DATA_W-1:0]  val_r;
  logic [PAGE_BITS-1:0]          page_r;
  logic [BW-1:0]                 q_r;
  logic [LAW-1:0]                rem_r;
  logic [31:0]                   page_ext;
  logic [PW-1:0]                 prod;
  logic [PW-1:0]                 quo;
  logic [PAGE_BITS-1:0]          qmul;
  logic [PAGE_BITS-1:0]          diff;

  assign page_ext = 32'(page);
  assign busy     = (state_r != F_IDLE);
  assign push     = (state_r == F_PUSH) && !full;
  assign entry    = {op_r, t_r, q_r, rem_r, val_r};

  // block number, then offset from the registered block number
  assign prod = PW'(page_r) * PW'(RECIP_M);
  assign quo  = prod >> SH;
  assign qmul = PAGE_BITS'(q_r) * PAGE_BITS'(LINE_ENTRIES);
  assign diff = page_r - qmul;

  // control and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (take) begin
            op_r    <= opcode;
            t_r     <= table_sel;
            val_r   <= value;
            page_r  <= page_ext[PAGE_BITS-1:0];
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          q_r     <= quo[BW-1:0];
          state_r <= F_REM;
        end
        F_REM: begin
          rem_r   <= diff[LAW-1:0];
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/sltbc_back.sv */
// ----------------------------------------------------------------------------
// sltbc_back
// Carries out queued accesses: block switch with write-back and fetch
// bursts, then the entry read or write. Clears both memories after reset.
// ----------------------------------------------------------------------------
module sltbc_back #(
  parameter int PAGE_BITS    = 20,
  parameter int LINE_ENTRIES = 1024,
  localparam int LAW = $clog2(LINE_ENTRIES),
  localparam int NUM_BLK = ((1 << PAGE_BITS) + LINE_ENTRIES - 1) / LINE_ENTRIES,
  localparam int BW = (NUM_BLK > 1) ? $clog2(NUM_BLK) : 1,
  localparam int EW = 2 + BW + LAW + sltbc_pkg::DATA_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            empty,
  input  logic [EW-1:0]                   entry,
  output logic                            pop,
  output sltbc_pkg::back_stat_t           stat,
  output logic                            out_strobe,
  output logic [sltbc_pkg::DATA_W-1:0]    out_read_value,
  output logic                            out_block_switched,
  output logic                            out_wrote_back,
  output logic [sltbc_pkg::OUT_BLK_W-1:0] out_evicted_block,
  output logic [sltbc_pkg::OUT_BLK_W-1:0] out_fetched_block
);

  localparam int DW  = sltbc_pkg::DATA_W;
  localparam int TW  = 1 << PAGE_BITS;
  localparam int IW  = PAGE_BITS + 1;
  localparam int CW  = $clog2(LINE_ENTRIES + 1);
  localparam int LDA = LAW + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_WB, S_FSET, S_FE, S_ACC, S_RD
  } bstate_t;

  bstate_t           state_r;
  logic [IW-1:0]     clr_r;
  logic              op_r;
  logic              t_r;
  logic [BW-1:0]     blk_r;
  logic [LAW-1:0]    off_r;
  logic [DW-1:0]     val_r;
  logic [BW-1:0]     tag_r [2];
  logic [1:0]        dirty_r;
  logic [BW-1:0]     old_r;
  logic              sw_r;
  logic              wb_r;
  logic [CW-1:0]     cnt_r;
  logic [IW-1:0]     idx_r;
  logic              pv_r;
  logic [IW-1:0]     pidx_r;
  logic [LAW-1:0]    pcnt_r;
  logic              strobe_r;
  logic [DW-1:0]     rv_r;

  logic              line_we;
  logic [LDA-1:0]    line_waddr;
  logic [DW-1:0]     line_wdata;
  logic [LDA-1:0]    line_raddr;
  logic [DW-1:0]     line_rdata;
  logic              bk_we;
  logic [IW-1:0]     bk_waddr;
  logic [DW-1:0]     bk_wdata;
  logic [IW-1:0]     bk_raddr;
  logic [DW-1:0]     bk_rdata;
  logic              more;
  logic [31:0]       old_ext;
  logic [31:0]       blk_ext;

  assign pop           = (state_r == S_IDLE) && !empty;
  assign stat.clearing = (state_r == S_CLEAR);
  assign more          = (cnt_r < CW'(LINE_ENTRIES));
  assign old_ext       = 32'(old_r);
  assign blk_ext       = 32'(blk_r);

  assign out_strobe         = strobe_r;
  assign out_read_value     = rv_r;
  assign out_block_switched = sw_r;
  assign out_wrote_back     = wb_r;
  assign out_evicted_block  = old_ext[sltbc_pkg::OUT_BLK_W-1:0];
  assign out_fetched_block  = blk_ext[sltbc_pkg::OUT_BLK_W-1:0];

  // line buffers, both tables
  sltbc_ram #(.W(DW), .D(2 << LAW)) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  // backing store, both tables
  sltbc_ram #(.W(DW), .D(2 * TW)) u_backing (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (bk_wdata),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  // memory port steering
  always_comb begin
    line_we    = 1'b0;
    line_waddr = '0;
    line_wdata = '0;
    line_raddr = '0;
    bk_we      = 1'b0;
    bk_waddr   = '0;
    bk_wdata   = '0;
    bk_raddr   = '0;
    case (state_r)
      S_CLEAR: begin
        line_we    = 1'b1;
        line_waddr = clr_r[LAW:0];
        bk_we      = 1'b1;
        bk_waddr   = clr_r;
      end
      S_WB: begin
        line_raddr = {t_r, cnt_r[LAW-1:0]};
        if (pv_r && (pidx_r < IW'(TW))) begin
          bk_we    = 1'b1;
          bk_waddr = {t_r, pidx_r[PAGE_BITS-1:0]};
          bk_wdata = line_rdata;
        end
      end
      S_FE: begin
        bk_raddr = {t_r, idx_r[PAGE_BITS-1:0]};
        if (pv_r) begin
          line_we    = 1'b1;
          line_waddr = {t_r, pcnt_r};
          line_wdata = (pidx_r < IW'(TW)) ? bk_rdata : '0;
        end
      end
      S_ACC: begin
        if (op_r) begin
          line_we    = 1'b1;
          line_waddr = {t_r, off_r};
          line_wdata = val_r;
        end else begin
          line_raddr = {t_r, off_r};
        end
      end
      default: begin
        line_we = 1'b0;
      end
    endcase
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      tag_r[0]   <= '0;
      tag_r[1]   <= '0;
      dirty_r    <= '0;
      strobe_r   <= 1'b0;
      pv_r       <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + IW'(1);
          if (clr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty) begin
            {op_r, t_r, blk_r, off_r, val_r} <= entry;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          old_r <= tag_r[t_r];
          cnt_r <= '0;
          pv_r  <= 1'b0;
          if (blk_r != tag_r[t_r]) begin
            sw_r           <= 1'b1;
            dirty_r[t_r]   <= 1'b0;
            if (op_r || dirty_r[t_r]) begin
              wb_r    <= 1'b1;
              idx_r   <= IW'(tag_r[t_r]) * IW'(LINE_ENTRIES);
              state_r <= S_WB;
            end else begin
              wb_r    <= 1'b0;
              state_r <= S_FSET;
            end
          end else begin
            sw_r    <= 1'b0;
            wb_r    <= 1'b0;
            state_r <= S_ACC;
          end
        end
        S_WB: begin
          pv_r   <= more;
          pidx_r <= idx_r;
          if (more) begin
            cnt_r <= cnt_r + CW'(1);
            idx_r <= idx_r + IW'(1);
          end else begin
            state_r <= S_FSET;
          end
        end
        S_FSET: begin
          idx_r   <= IW'(blk_r) * IW'(LINE_ENTRIES);
          cnt_r   <= '0;
          pv_r    <= 1'b0;
          state_r <= S_FE;
        end
        S_FE: begin
          pv_r   <= more;
          pidx_r <= idx_r;
          pcnt_r <= cnt_r[LAW-1:0];
          if (more) begin
            cnt_r <= cnt_r + CW'(1);
            idx_r <= idx_r + IW'(1);
          end else begin
            tag_r[t_r] <= blk_r;
            state_r    <= S_ACC;
          end
        end
        S_ACC: begin
          if (op_r) begin
            dirty_r[t_r] <= 1'b1;
            rv_r         <= val_r;
            strobe_r     <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          rv_r     <= line_rdata;
          strobe_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/single_line_table_block_cache.sv */
// ----------------------------------------------------------------------------
// single_line_table_block_cache
// Two page-indexed tables in a backing memory, each with one write-back
// line buffer holding one block of entries.
// ----------------------------------------------------------------------------
// channel   handshake          word
// request   start / busy       in_opcode, in_table_sel, in_page, in_value
// result    out_strobe         out_read_value, out_block_switched,
//                              out_wrote_back, out_evicted_block,
//                              out_fetched_block
//
// The front works on one word at a time (accept, block by reciprocal multiply,
// offset by remainder, queue push), which sets the pace for accesses that
// stay in the buffered block; the back checks the tag, then writes the entry
// or reads it and registers the read data. A block switch adds a fetch burst
// of LINE_ENTRIES entries, after a write-back burst for a write or a dirty line.
// After reset both memories are cleared one entry a cycle, 2 * 2^PAGE_BITS
// backing entries, busy high. Results are shown for one cycle and never held.
// ----------------------------------------------------------------------------
module single_line_table_block_cache #(
  parameter int PAGE_BITS    = 20,
  parameter int LINE_ENTRIES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic                            in_table_sel,
  input  logic [sltbc_pkg::PAGE_IN_W-1:0] in_page,
  input  logic [sltbc_pkg::DATA_W-1:0]    in_value,
  output logic                            out_strobe,
  output logic [sltbc_pkg::DATA_W-1:0]    out_read_value,
  output logic                            out_block_switched,
  output logic                            out_wrote_back,
  output logic [sltbc_pkg::OUT_BLK_W-1:0] out_evicted_block,
  output logic [sltbc_pkg::OUT_BLK_W-1:0] out_fetched_block
);

  localparam int LAW = $clog2(LINE_ENTRIES);
  localparam int NUM_BLK = ((1 << PAGE_BITS) + LINE_ENTRIES - 1) / LINE_ENTRIES;
  localparam int BW = (NUM_BLK > 1) ? $clog2(NUM_BLK) : 1;
  localparam int EW = 2 + BW + LAW + sltbc_pkg::DATA_W;

  logic                  front_busy;
  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  empty;
  logic [EW-1:0]         q_in;
  logic [EW-1:0]         q_out;
  sltbc_pkg::back_stat_t bstat;

  // no requests while busy decoding or clearing memories
  assign busy = front_busy || bstat.clearing;

  sltbc_front #(.PAGE_BITS(PAGE_BITS), .LINE_ENTRIES(LINE_ENTRIES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (start && !busy),
    .opcode    (in_opcode),
    .table_sel (in_table_sel),
    .page      (in_page),
    .value     (in_value),
    .busy      (front_busy),
    .push      (push),
    .entry     (q_in),
    .full      (full)
  );

  sltbc_fifo #(.EW(EW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_in),
    .full  (full),
    .pop   (pop),
    .dout  (q_out),
    .empty (empty)
  );

  sltbc_back #(.PAGE_BITS(PAGE_BITS), .LINE_ENTRIES(LINE_ENTRIES)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .empty              (empty),
    .entry              (q_out),
    .pop                (pop),
    .stat               (bstat),
    .out_strobe         (out_strobe),
    .out_read_value     (out_read_value),
    .out_block_switched (out_block_switched),
    .out_wrote_back     (out_wrote_back),
    .out_evicted_block  (out_evicted_block),
    .out_fetched_block  (out_fetched_block)
  );

endmodule

/* tb/sv/tb_single_line_table_block_cache.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_single_line_table_block_cache
// Drives table reads and writes through the start / busy handshake, keeps
// its own copy of both line buffers and of the backing memory, and checks
// every strobed result word field by field against the predicted access.
// ----------------------------------------------------------------------------
module tb_single_line_table_block_cache;

  localparam int TBL_BITS   = 20;
  localparam int LINE_WORDS = 1024;
  localparam int NUM_RANDOM = 1300;
  localparam int QUIET_TAIL = 200;
  // clearing pass plus every word switching with write-back, taken several times
  localparam longint CYCLE_LIMIT = 24_000_000;

  typedef enum logic {OP_READ = 1'b0, OP_WRITE = 1'b1} op_e;
  typedef enum logic {TBL_WRITE_LOOKUP = 1'b0, TBL_READ_LOOKUP = 1'b1} tbl_e;

  typedef struct {
    op_e                             op;
    tbl_e                            tsel;
    logic [sltbc_pkg::PAGE_IN_W-1:0] page;
    logic [sltbc_pkg::DATA_W-1:0]    value;
  } access_t;

  typedef struct {
    logic [sltbc_pkg::DATA_W-1:0]    read_value;
    logic                            switched;
    logic                            wrote_back;
    logic [sltbc_pkg::OUT_BLK_W-1:0] evicted;
    logic [sltbc_pkg::OUT_BLK_W-1:0] fetched;
  } lookup_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = 1'b0;
  logic in_table_sel = 1'b0;
  logic [sltbc_pkg::PAGE_IN_W-1:0] in_page = '0;
  logic [sltbc_pkg::DATA_W-1:0] in_value = '0;
  logic out_strobe;
  logic [sltbc_pkg::DATA_W-1:0] out_read_value;
  logic out_block_switched;
  logic out_wrote_back;
  logic [sltbc_pkg::OUT_BLK_W-1:0] out_evicted_block;
  logic [sltbc_pkg::OUT_BLK_W-1:0] out_fetched_block;

  single_line_table_block_cache i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_table_sel       (in_table_sel),
    .in_page            (in_page),
    .in_value           (in_value),
    .out_strobe         (out_strobe),
    .out_read_value     (out_read_value),
    .out_block_switched (out_block_switched),
    .out_wrote_back     (out_wrote_back),
    .out_evicted_block  (out_evicted_block),
    .out_fetched_block  (out_fetched_block)
  );

  always #1 clk = ~clk;

  // shadow state of the block
  logic [sltbc_pkg::DATA_W-1:0] backing_mem [bit [TBL_BITS:0]];
  logic [sltbc_pkg::DATA_W-1:0] line_copy [2][LINE_WORDS];
  logic [9:0]        line_tag [2];
  logic              line_dirty [2];

  access_t pending_words[$];
  lookup_t expected_lookups[$];
  int      mismatch_count = 0;
  int      words_issued = 0;
  int      gap_left = 0;
  longint  cycle_count = 0;

  task automatic report_mismatch(input string what,
                                 input logic [sltbc_pkg::DATA_W-1:0] got,
                                 input logic [sltbc_pkg::DATA_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // predict one table access and queue its result
  task automatic predict_lookup(input access_t a);
    lookup_t r;
    int t;
    logic [9:0] blk;
    logic [9:0] off;
    bit [TBL_BITS:0] key;
    t   = int'(a.tsel);
    blk = a.page[19:10];
    off = a.page[9:0];
    r.evicted    = line_tag[t];
    r.switched   = (blk != line_tag[t]);
    r.wrote_back = 1'b0;
    if (r.switched) begin
      if (a.op == OP_WRITE || line_dirty[t]) begin
        r.wrote_back = 1'b1;
        for (int i = 0; i < LINE_WORDS; i++) begin
          key = {a.tsel, line_tag[t], 10'(i)};
          backing_mem[key] = line_copy[t][i];
        end
      end
      for (int i = 0; i < LINE_WORDS; i++) begin
        key = {a.tsel, blk, 10'(i)};
        line_copy[t][i] = backing_mem.exists(key) ? backing_mem[key] : '0;
      end
      line_dirty[t] = 1'b0;
      line_tag[t]   = blk;
    end
    if (a.op == OP_WRITE) begin
      line_copy[t][off] = a.value;
      line_dirty[t]     = 1'b1;
    end
    r.read_value = line_copy[t][off];
    r.fetched    = line_tag[t];
    expected_lookups.push_back(r);
  endtask

  function automatic access_t mk(op_e op, tbl_e ts, logic [19:0] pg, logic [31:0] v);
    access_t a;
    a.op = op; a.tsel = ts; a.page = pg; a.value = v;
    return a;
  endfunction

  // driver: hold the word until accepted, then maybe idle a burst
  always @(posedge clk) begin
    access_t nxt;
    logic next_start;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        predict_lookup(mk(op_e'(in_opcode), tbl_e'(in_table_sel), in_page, in_value));
        words_issued++;
        if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 4) == 0)
          gap_left = $urandom_range(1, 15);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          next_start = 1'b0;
        end else if (pending_words.size() > 0) begin
          nxt = pending_words.pop_front();
          in_opcode    <= nxt.op;
          in_table_sel <= nxt.tsel;
          in_page      <= nxt.page;
          in_value     <= nxt.value;
          next_start = 1'b1;
        end else begin
          next_start = 1'b0;
        end
      end
      start <= next_start;
    end
  end

  // monitor: every strobe must match the oldest expectation
  always @(posedge clk) begin
    lookup_t e;
    if (rst_n && out_strobe) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch("unexpected result word", out_read_value, '0);
      end else begin
        e = expected_lookups.pop_front();
        if (out_read_value !== e.read_value)
          report_mismatch("read_value", out_read_value, e.read_value);
        if (out_block_switched !== e.switched)
          report_mismatch("block_switched", 32'(out_block_switched), 32'(e.switched));
        if (out_wrote_back !== e.wrote_back)
          report_mismatch("wrote_back", 32'(out_wrote_back), 32'(e.wrote_back));
        if (out_evicted_block !== e.evicted)
          report_mismatch("evicted_block", 32'(out_evicted_block), 32'(e.evicted));
        if (out_fetched_block !== e.fetched)
          report_mismatch("fetched_block", 32'(out_fetched_block), 32'(e.fetched));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [9:0] cur_blk [2];
    logic [9:0] blk_pool [6];
    tbl_e ts;
    op_e op;
    int total_words;
    for (int t = 0; t < 2; t++) begin
      line_tag[t]   = '0;
      line_dirty[t] = 1'b0;
      for (int i = 0; i < LINE_WORDS; i++) line_copy[t][i] = '0;
    end

    // directed: extremes, clean and dirty switches, hits
    pending_words.push_back(mk(OP_READ,  TBL_WRITE_LOOKUP, 20'h00000, 32'h0));
    pending_words.push_back(mk(OP_WRITE, TBL_WRITE_LOOKUP, 20'h00000, 32'hffffffff));
    pending_words.push_back(mk(OP_WRITE, TBL_WRITE_LOOKUP, 20'h003ff, 32'h12345678));
    pending_words.push_back(mk(OP_READ,  TBL_WRITE_LOOKUP, 20'h00000, 32'hdeadbeef));
    // write switch from dirty line, then read switch back with dirty line
    pending_words.push_back(mk(OP_WRITE, TBL_WRITE_LOOKUP, 20'hfffff, 32'ha5a5a5a5));
    pending_words.push_back(mk(OP_READ,  TBL_WRITE_LOOKUP, 20'h00000, 32'h0));
    pending_words.push_back(mk(OP_READ,  TBL_WRITE_LOOKUP, 20'hffc00, 32'h0));
    pending_words.push_back(mk(OP_READ,  TBL_WRITE_LOOKUP, 20'hfffff, 32'h0));
    // clean read switch, then write switch from clean line
    pending_words.push_back(mk(OP_READ,  TBL_WRITE_LOOKUP, 20'h00400, 32'h0));
    pending_words.push_back(mk(OP_WRITE, TBL_WRITE_LOOKUP, 20'h80000, 32'h00000001));
    pending_words.push_back(mk(OP_WRITE, TBL_WRITE_LOOKUP, 20'h80000, 32'h80000000));
    // other table is independent
    pending_words.push_back(mk(OP_READ,  TBL_READ_LOOKUP, 20'h00000, 32'h0));
    pending_words.push_back(mk(OP_WRITE, TBL_READ_LOOKUP, 20'h00001, 32'h55555555));
    pending_words.push_back(mk(OP_READ,  TBL_READ_LOOKUP, 20'h7ffff, 32'h0));
    pending_words.push_back(mk(OP_READ,  TBL_READ_LOOKUP, 20'h00001, 32'h0));
    pending_words.push_back(mk(OP_READ,  TBL_WRITE_LOOKUP, 20'h80000, 32'h0));

    // random: mostly hits in the current block, switches among a small pool or to a random block
    blk_pool[0] = 10'd0;   blk_pool[1] = 10'd1;   blk_pool[2] = 10'd1023;
    blk_pool[3] = 10'd512; blk_pool[4] = 10'd341; blk_pool[5] = 10'd682;
    cur_blk[0] = 10'd512;
    cur_blk[1] = 10'd1;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      ts = tbl_e'($urandom_range(0, 1));
      op = tbl_e'(0) == ts ? op_e'($urandom_range(0, 1)) : op_e'($urandom_range(0, 1));
      if ($urandom_range(0, 11) == 0)
        cur_blk[ts] = ($urandom_range(0, 3) == 0) ? 10'($urandom) : blk_pool[$urandom_range(0, 5)];
      pending_words.push_back(mk(op, ts,
        {cur_blk[ts], ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 7)) : 10'($urandom)},
        ($urandom_range(0, 9) == 0) ? 32'hffffffff : 32'($urandom)));
    end
    total_words = pending_words.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // every word accepted, then every result seen
    wait (words_issued == total_words);
    wait (expected_lookups.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_lookups.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
